### rtl/assert_macros.svh
// Assertion macros shared by the descriptor checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, bad) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(bad)) \
        else $error("forbidden condition seen");

`endif

### rtl/ggtd_pkg.sv
// Types and constants for the GEMM gradient tile descriptor checker.
`default_nettype none

package ggtd_pkg;

    localparam int SPAN_CNT   = 3;
    localparam int SPAN_WEIGHT = 0;
    localparam int SPAN_GRAD   = 1;
    localparam int SPAN_RESULT = 2;

    localparam int DIM_W      = 30;  // validated sizes are below 2^30
    localparam int PROD_W     = 2 * DIM_W;
    localparam int ADDR_W     = 25;  // covers any in-range SRAM address
    localparam int RECIP_W    = ADDR_W + 1;
    localparam int MOD_PROD_W = ADDR_W + RECIP_W;
    localparam int ALIGN_W    = 13;
    localparam int FMA_W      = 23;

    localparam logic KIND_FP16 = 1'b0;
    localparam logic KIND_FP32 = 1'b1;
    localparam logic [SPAN_CNT-1:0] KIND_WANT = {KIND_FP32, KIND_FP16, KIND_FP16};

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SIZE    = 3'd1;
    localparam logic [2:0] ST_WEIGHT  = 3'd2;
    localparam logic [2:0] ST_GRAD    = 3'd3;
    localparam logic [2:0] ST_RESULT  = 3'd4;
    localparam logic [2:0] ST_OVERLAP = 3'd5;

    typedef struct packed {
        logic [31:0]                size_k;
        logic [31:0]                size_m;
        logic [31:0]                size_n;
        logic [SPAN_CNT-1:0][31:0]  addr;
        logic [SPAN_CNT-1:0][31:0]  len;
        logic [SPAN_CNT-1:0]        kind;
    } desc_t;

    typedef struct packed {
        logic                              size_bad;
        logic [SPAN_CNT-1:0]               span_bad;
        logic [DIM_W-1:0]                  k;
        logic [DIM_W-1:0]                  m;
        logic [DIM_W-1:0]                  n;
        logic [SPAN_CNT-1:0][31:0]         addr;
        logic [SPAN_CNT-1:0][31:0]         len;
        logic [SPAN_CNT-1:0][MOD_PROD_W-1:0] mod_prod;
    } screen_t;

    typedef struct packed {
        logic                           size_bad;
        logic [SPAN_CNT-1:0]            span_bad;
        logic [SPAN_CNT-1:0][ADDR_W-1:0] addr_lo;
        logic [SPAN_CNT-1:0][ADDR_W-1:0] qd;
        logic [SPAN_CNT-1:0][31:0]      len;
        logic [PROD_W-1:0]              mn;
        logic [PROD_W-1:0]              kn;
        logic [PROD_W-1:0]              km;
        logic [FMA_W-1:0]               k_lo;
        logic                           overlap;
    } mult_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [16:0] weight_read_bytes;
        logic [16:0] grad_read_bytes;
        logic [17:0] rmw_bytes;
        logic [22:0] fma_count;
        logic [23:0] flop_count;
        logic [14:0] vector_ops;
    } res_t;

endpackage

`default_nettype wire

### rtl/ggtd_screen.sv
// Stage 1: size limits, per-span type/length/fit checks, alignment reciprocal product.
`default_nettype none

module ggtd_screen #(
    parameter int SRAM_BYTES = 65536,
    parameter int DIM_LIMIT  = 1073741823,
    parameter int SPAN_ALIGN = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire ggtd_pkg::desc_t in_desc,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output ggtd_pkg::screen_t    out_data
);

    localparam logic [31:0] SRAM_C = 32'(SRAM_BYTES);
    localparam logic [31:0] DIM_C  = 32'(DIM_LIMIT);
    localparam logic [ggtd_pkg::RECIP_W-1:0] RECIP =
        ggtd_pkg::RECIP_W'((64'd1 << ggtd_pkg::ADDR_W) / SPAN_ALIGN);

    logic              valid_reg, valid_next;
    ggtd_pkg::screen_t data_reg, data_next;
    ggtd_pkg::screen_t calc;

    always_comb begin
        calc.size_bad = (in_desc.size_k == 32'd0) || (in_desc.size_m == 32'd0) ||
                        (in_desc.size_n == 32'd0) || (in_desc.size_k > DIM_C) ||
                        (in_desc.size_m > DIM_C) || (in_desc.size_n > DIM_C);
        calc.k    = in_desc.size_k[ggtd_pkg::DIM_W-1:0];
        calc.m    = in_desc.size_m[ggtd_pkg::DIM_W-1:0];
        calc.n    = in_desc.size_n[ggtd_pkg::DIM_W-1:0];
        calc.addr = in_desc.addr;
        calc.len  = in_desc.len;
        for (int i = 0; i < ggtd_pkg::SPAN_CNT; i++) begin
            // SRAM_C - addr may wrap, but only when addr > SRAM_C already fails
            calc.span_bad[i] = (in_desc.kind[i] != ggtd_pkg::KIND_WANT[i]) ||
                               (in_desc.len[i] == 32'd0) ||
                               (in_desc.addr[i] > SRAM_C) ||
                               (in_desc.len[i] > (SRAM_C - in_desc.addr[i]));
            // quotient estimate for addr mod SPAN_ALIGN, corrected two stages on
            calc.mod_prod[i] =
                ggtd_pkg::MOD_PROD_W'(in_desc.addr[i][ggtd_pkg::ADDR_W-1:0]) *
                ggtd_pkg::MOD_PROD_W'(RECIP);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
        data_next  = (in_valid && in_ready) ? calc : data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

### rtl/ggtd_mult.sv
// Stage 2: dimension products, alignment quotient back-multiply, span overlap.
`default_nettype none

module ggtd_mult #(
    parameter int SPAN_ALIGN = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ggtd_pkg::screen_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ggtd_pkg::mult_t        out_data
);

    localparam logic [ggtd_pkg::ALIGN_W-1:0] ALIGN_C = ggtd_pkg::ALIGN_W'(SPAN_ALIGN);
    localparam int QD_W = ggtd_pkg::RECIP_W + ggtd_pkg::ALIGN_W;

    logic            valid_reg, valid_next;
    ggtd_pkg::mult_t data_reg, data_next;
    ggtd_pkg::mult_t calc;
    logic [QD_W-1:0] qd_full [ggtd_pkg::SPAN_CNT];

    function automatic logic spans_meet(input logic [31:0] a_addr, input logic [31:0] a_len,
                                        input logic [31:0] b_addr, input logic [31:0] b_len);
        logic [32:0] a_end;
        logic [32:0] b_end;
        a_end = {1'b0, a_addr} + {1'b0, a_len};
        b_end = {1'b0, b_addr} + {1'b0, b_len};
        return ({1'b0, a_addr} < b_end) && ({1'b0, b_addr} < a_end);
    endfunction

    always_comb begin
        calc.size_bad = in_data.size_bad;
        calc.span_bad = in_data.span_bad;
        calc.len      = in_data.len;
        calc.mn       = ggtd_pkg::PROD_W'(in_data.m) * ggtd_pkg::PROD_W'(in_data.n);
        calc.kn       = ggtd_pkg::PROD_W'(in_data.k) * ggtd_pkg::PROD_W'(in_data.n);
        calc.km       = ggtd_pkg::PROD_W'(in_data.k) * ggtd_pkg::PROD_W'(in_data.m);
        calc.k_lo     = in_data.k[ggtd_pkg::FMA_W-1:0];
        for (int i = 0; i < ggtd_pkg::SPAN_CNT; i++) begin
            calc.addr_lo[i] = in_data.addr[i][ggtd_pkg::ADDR_W-1:0];
            qd_full[i] = QD_W'(in_data.mod_prod[i][ggtd_pkg::MOD_PROD_W-1:ggtd_pkg::ADDR_W]) *
                         QD_W'(ALIGN_C);
            // estimate never exceeds the address, so the low bits hold it
            calc.qd[i] = qd_full[i][ggtd_pkg::ADDR_W-1:0];
        end
        calc.overlap =
            spans_meet(in_data.addr[ggtd_pkg::SPAN_WEIGHT], in_data.len[ggtd_pkg::SPAN_WEIGHT],
                       in_data.addr[ggtd_pkg::SPAN_GRAD], in_data.len[ggtd_pkg::SPAN_GRAD]) ||
            spans_meet(in_data.addr[ggtd_pkg::SPAN_WEIGHT], in_data.len[ggtd_pkg::SPAN_WEIGHT],
                       in_data.addr[ggtd_pkg::SPAN_RESULT], in_data.len[ggtd_pkg::SPAN_RESULT]) ||
            spans_meet(in_data.addr[ggtd_pkg::SPAN_GRAD], in_data.len[ggtd_pkg::SPAN_GRAD],
                       in_data.addr[ggtd_pkg::SPAN_RESULT], in_data.len[ggtd_pkg::SPAN_RESULT]);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
        data_next  = (in_valid && in_ready) ? calc : data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

### rtl/ggtd_judge.sv
// Stage 3: length match, alignment remainder, status priority and result counts.
`default_nettype none

module ggtd_judge #(
    parameter int SPAN_ALIGN = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire ggtd_pkg::mult_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output ggtd_pkg::res_t       out_data
);

    localparam logic [ggtd_pkg::ADDR_W-1:0] ALIGN_C = ggtd_pkg::ADDR_W'(SPAN_ALIGN);

    logic                       valid_reg, valid_next;
    ggtd_pkg::res_t             data_reg, data_next;
    ggtd_pkg::res_t             calc;
    logic [ggtd_pkg::SPAN_CNT-1:0] len_ok;
    logic [ggtd_pkg::SPAN_CNT-1:0] aligned;
    logic [ggtd_pkg::SPAN_CNT-1:0] bad;
    logic [ggtd_pkg::ADDR_W-1:0]   rem [ggtd_pkg::SPAN_CNT];
    logic [ggtd_pkg::FMA_W-1:0]    fma;
    logic                          ok;

    always_comb begin
        len_ok[ggtd_pkg::SPAN_WEIGHT] = (in_data.mn[ggtd_pkg::PROD_W-1:31] == '0) &&
            ({in_data.mn[30:0], 1'b0} == in_data.len[ggtd_pkg::SPAN_WEIGHT]);
        len_ok[ggtd_pkg::SPAN_GRAD] = (in_data.kn[ggtd_pkg::PROD_W-1:31] == '0) &&
            ({in_data.kn[30:0], 1'b0} == in_data.len[ggtd_pkg::SPAN_GRAD]);
        len_ok[ggtd_pkg::SPAN_RESULT] = (in_data.km[ggtd_pkg::PROD_W-1:30] == '0) &&
            ({in_data.km[29:0], 2'b00} == in_data.len[ggtd_pkg::SPAN_RESULT]);
        for (int i = 0; i < ggtd_pkg::SPAN_CNT; i++) begin
            // quotient may be one short: remainder lands in [0, 2*align)
            rem[i]     = in_data.addr_lo[i] - in_data.qd[i];
            aligned[i] = (rem[i] == '0) || (rem[i] == ALIGN_C);
            bad[i]     = in_data.span_bad[i] || !len_ok[i] || !aligned[i];
        end

        if (in_data.size_bad) begin
            calc.status = ggtd_pkg::ST_SIZE;
        end else if (bad[ggtd_pkg::SPAN_WEIGHT]) begin
            calc.status = ggtd_pkg::ST_WEIGHT;
        end else if (bad[ggtd_pkg::SPAN_GRAD]) begin
            calc.status = ggtd_pkg::ST_GRAD;
        end else if (bad[ggtd_pkg::SPAN_RESULT]) begin
            calc.status = ggtd_pkg::ST_RESULT;
        end else if (in_data.overlap) begin
            calc.status = ggtd_pkg::ST_OVERLAP;
        end else begin
            calc.status = ggtd_pkg::ST_OK;
        end
        ok = (calc.status == ggtd_pkg::ST_OK);

        // only the low bits of K*M*N survive the output masks
        fma = in_data.k_lo * in_data.mn[ggtd_pkg::FMA_W-1:0];

        calc.weight_read_bytes = ok ? {in_data.mn[15:0], 1'b0} : '0;
        calc.grad_read_bytes   = ok ? {in_data.kn[15:0], 1'b0} : '0;
        calc.rmw_bytes         = ok ? {in_data.km[14:0], 3'b000} : '0;
        calc.fma_count         = ok ? fma : '0;
        calc.flop_count        = ok ? {fma, 1'b0} : '0;
        calc.vector_ops        = ok ? in_data.km[14:0] : '0;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
        data_next  = (in_valid && in_ready) ? calc : data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

### rtl/gemm_grad_tile_descriptor_check.sv
// Top level of the GEMM input-gradient tile descriptor checker.
// Checks one tile descriptor (K/M/N sizes plus weight, upstream gradient and
// output SRAM spans) and returns a status code with byte and operation counts,
// all counts zero on any error. Three register stages: size and span-bound
// screening, the dimension multipliers with overlap tests, then length match,
// alignment and status priority. An accepted request is registered by the
// screen, mult and judge stages in turn, and m_valid rises when the judge
// stage holds its result; one request is accepted every cycle while the
// result side keeps taking. Each stage holds its request while the next is
// full, and ready travels back through the stages combinationally from
// m_ready, so an empty stage still accepts while a finished result waits at
// the output.
`default_nettype none
`include "assert_macros.svh"

module gemm_grad_tile_descriptor_check #(
    parameter int SRAM_BYTES = 65536,
    parameter int DIM_LIMIT  = 1073741823,
    parameter int SPAN_ALIGN = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_size_k,
    input  wire logic [31:0] s_size_m,
    input  wire logic [31:0] s_size_n,
    input  wire logic [31:0] s_weight_addr,
    input  wire logic [31:0] s_weight_len,
    input  wire logic        s_weight_kind,
    input  wire logic [31:0] s_grad_addr,
    input  wire logic [31:0] s_grad_len,
    input  wire logic        s_grad_kind,
    input  wire logic [31:0] s_result_addr,
    input  wire logic [31:0] s_result_len,
    input  wire logic        s_result_kind,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [16:0]      m_weight_read_bytes,
    output logic [16:0]      m_grad_read_bytes,
    output logic [17:0]      m_rmw_bytes,
    output logic [22:0]      m_fma_count,
    output logic [23:0]      m_flop_count,
    output logic [14:0]      m_vector_ops
);

    ggtd_pkg::desc_t   desc;
    ggtd_pkg::screen_t scr_data;
    ggtd_pkg::mult_t   mul_data;
    ggtd_pkg::res_t    res;
    logic              scr_valid, scr_ready;
    logic              mul_valid, mul_ready;
    logic              counts_zero;

    always_comb begin
        desc.size_k = s_size_k;
        desc.size_m = s_size_m;
        desc.size_n = s_size_n;
        desc.addr[ggtd_pkg::SPAN_WEIGHT] = s_weight_addr;
        desc.len[ggtd_pkg::SPAN_WEIGHT]  = s_weight_len;
        desc.kind[ggtd_pkg::SPAN_WEIGHT] = s_weight_kind;
        desc.addr[ggtd_pkg::SPAN_GRAD]   = s_grad_addr;
        desc.len[ggtd_pkg::SPAN_GRAD]    = s_grad_len;
        desc.kind[ggtd_pkg::SPAN_GRAD]   = s_grad_kind;
        desc.addr[ggtd_pkg::SPAN_RESULT] = s_result_addr;
        desc.len[ggtd_pkg::SPAN_RESULT]  = s_result_len;
        desc.kind[ggtd_pkg::SPAN_RESULT] = s_result_kind;
    end

    ggtd_screen #(
        .SRAM_BYTES (SRAM_BYTES),
        .DIM_LIMIT  (DIM_LIMIT),
        .SPAN_ALIGN (SPAN_ALIGN)
    ) u_screen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_desc   (desc),
        .out_valid (scr_valid),
        .out_ready (scr_ready),
        .out_data  (scr_data)
    );

    ggtd_mult #(
        .SPAN_ALIGN (SPAN_ALIGN)
    ) u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (scr_valid),
        .in_ready  (scr_ready),
        .in_data   (scr_data),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_data  (mul_data)
    );

    ggtd_judge #(
        .SPAN_ALIGN (SPAN_ALIGN)
    ) u_judge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_data   (mul_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res)
    );

    assign m_status            = res.status;
    assign m_weight_read_bytes = res.weight_read_bytes;
    assign m_grad_read_bytes   = res.grad_read_bytes;
    assign m_rmw_bytes         = res.rmw_bytes;
    assign m_fma_count         = res.fma_count;
    assign m_flop_count        = res.flop_count;
    assign m_vector_ops        = res.vector_ops;

    assign counts_zero = (m_weight_read_bytes == '0) && (m_grad_read_bytes == '0) &&
                         (m_rmw_bytes == '0) && (m_fma_count == '0) &&
                         (m_flop_count == '0) && (m_vector_ops == '0);

    `ASSERT_NEVER(a_status_range, aclk, aresetn, m_valid && (m_status > ggtd_pkg::ST_OVERLAP))
    `ASSERT_IMPLY(a_err_zero, aclk, aresetn, m_valid && (m_status != ggtd_pkg::ST_OK), counts_zero)
    `ASSERT_IMPLY(a_flop_twice, aclk, aresetn, m_valid, m_flop_count == {m_fma_count, 1'b0})
    `ASSERT_IMPLY(a_rmw_vec, aclk, aresetn, m_valid, m_rmw_bytes == {m_vector_ops, 3'b000})

endmodule

`default_nettype wire
